### sv/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/mhba_pkg.sv
// Shared types and constants for the min-heap block allocator.
// No dependencies; imported by every module of the block except mhba_ram.
`timescale 1ns / 1ps
package mhba_pkg;

  localparam int HEAP_ENTRIES = 1024;
  localparam int HEAP_AW      = $clog2(HEAP_ENTRIES);
  localparam int CNT_W        = HEAP_AW + 1;
  localparam int HEADER_BYTES = 24;
  localparam int REGION_MAX   = 65536;
  localparam int TAB_DEPTH    = REGION_MAX / 4;
  localparam int TAB_AW       = $clog2(TAB_DEPTH);
  localparam int KEY_W        = 16;
  localparam int REG_W        = 17;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_INIT  = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] addr;
  } heap_ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_ROOT, S_PLAST, S_PCHK, S_PL, S_PR, S_PCMP,
    S_GRANT, S_FIN, S_FKEY, S_PUT, S_UCHK, S_UCMP, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_INIT, OP_RD_ROOT, OP_RD_TAB, OP_LD_TAB,
    OP_POP_BEGIN, OP_POP_LAST, OP_RD_L, OP_LD_L, OP_LD_R, OP_WR_LK,
    OP_MOVE_DN, OP_SPLIT, OP_NOSPLIT, OP_FIN, OP_PUT, OP_RD_UP,
    OP_MOVE_UP, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       set_st;
    logic [1:0] st;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic             addr_low;
    logic             region_big;
    logic             empty;
    logic             nofit;
    logic             child_ok;
    logic             right_ok;
    logic             sift_stop;
    logic             split;
    logic             full;
    logic             i_zero;
    logic             up_stop;
    logic [CNT_W-1:0] count;
  } dp_sts_t;

endpackage

### sv/min_heap_block_allocator_top.sv
// Top level of the min-heap free-block allocator: ports, controller, datapath.
// Depends on mhba_pkg, mhba_ctrl, mhba_dp and assert_macros.svh.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser=mode, tdata=req_size,addr
//  m_*       out  m_tvalid/m_tready  tuser=status, tdata=granted_addr,granted_size
//  cfg_*     in   cfg_we             cfg_wdata=region_bytes
//
// One operation at a time; each beat's length is set by the heap sift loops:
// a sift-down level does two child reads, a compare and a write, and a sift-up
// level a parent read and a compare-and-move, over the heap RAM's one read port.
// A finished result waits in the output register while the next beat is taken.
// Reset is synchronous: it empties the heap count and restores region_bytes; no
// memory clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module min_heap_block_allocator_top
  import mhba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,   // [15:0] req_size, [31:16] addr
  input  logic [1:0]       s_tuser,   // [1:0] mode
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,   // [15:0] granted_addr, [31:16] granted_size
  output logic [1:0]       m_tuser,   // [1:0] status
  input  logic             cfg_we,
  input  logic [REG_W-1:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [1:0] status;
  logic [15:0] gaddr, gsize;

  mhba_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .sts(sts), .cmd(cmd)
  );

  mhba_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_mode(s_tuser), .in_req(s_tdata[15:0]), .in_addr(s_tdata[31:16]),
    .out_status(status), .out_gaddr(gaddr), .out_gsize(gsize)
  );

  // Pack the held result beat.
  assign m_tuser = status;
  assign m_tdata = {gsize, gaddr};

  // Heap never holds more blocks than it has entries.
  `ASSERT_ALWAYS(a_count_bound, clk, rst, sts.count <= CNT_W'(HEAP_ENTRIES), "heap count overflow")
  // A taken beat blocks the input until its result is produced.
  `ASSERT_NEXT(a_busy_after_take, clk, rst, s_tvalid && s_tready, !s_tready, "ready after accept")
  // Heap count moves only while an operation is in flight.
  `ASSERT_NEXT(a_count_idle, clk, rst, s_tready, $stable(sts.count), "count moved while idle")

endmodule

### sv/mhba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mhba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/mhba_dp.sv
// Datapath: heap and size-table memories, sift registers, result registers.
// Depends on mhba_pkg and mhba_ram; driven by mhba_ctrl commands.
`timescale 1ns / 1ps
module mhba_dp
  import mhba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  input  logic             cfg_we,
  input  logic [REG_W-1:0] cfg_wdata,
  input  logic [1:0]       in_mode,
  input  logic [15:0]      in_req,
  input  logic [15:0]      in_addr,
  output logic [1:0]       out_status,
  output logic [15:0]      out_gaddr,
  output logic [15:0]      out_gsize
);

  logic [REG_W-1:0]   region;
  logic [CNT_W-1:0]   count;
  logic [HEAP_AW-1:0] i;
  logic [HEAP_AW-1:0] cidx;
  logic [1:0]         mode;
  logic [16:0]        need;
  logic [15:0]        addr_r;
  logic [KEY_W-1:0]   lk, la, key, hdr;
  heap_ent_t          cand;
  logic [1:0]         res_st;
  logic [15:0]        res_gaddr, res_gsize;

  logic               h_we;
  logic [HEAP_AW-1:0] h_waddr, h_raddr;
  heap_ent_t          h_wdata, h_rdata;
  logic               t_we;
  logic [TAB_AW-1:0]  t_waddr, t_raddr;
  logic [KEY_W-1:0]   t_wdata, t_rdata;

  logic [CNT_W:0]     l_idx, r_idx;
  logic [HEAP_AW-1:0] up_idx;
  logic [REG_W-1:0]   region_eff;
  logic [KEY_W-1:0]   init_key, free_hdr, nhdr, nkey;

  mhba_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(HEAP_ENTRIES)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  mhba_ram #(.WIDTH(KEY_W), .DEPTH(TAB_DEPTH)) u_tab (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  always_comb begin
    l_idx      = (CNT_W+1)'({i, 1'b1});
    r_idx      = l_idx + 1'b1;
    up_idx     = HEAP_AW'((i - 1'b1) >> 1);
    region_eff = (region > REG_W'(REGION_MAX)) ? REG_W'(REGION_MAX) : region;
    init_key   = KEY_W'(region_eff - REG_W'(HEADER_BYTES));
    free_hdr   = addr_r - 16'(HEADER_BYTES);
    nhdr       = hdr + 16'(HEADER_BYTES) + need[15:0];
    nkey       = key - need[15:0] - 16'(HEADER_BYTES);

    sts.mode       = mode;
    sts.addr_low   = addr_r < 16'(HEADER_BYTES);
    sts.region_big = region > REG_W'(HEADER_BYTES);
    sts.empty      = count == '0;
    sts.nofit      = {1'b0, h_rdata.key} < need;
    sts.child_ok   = l_idx < (CNT_W+1)'(count);
    sts.right_ok   = r_idx < (CNT_W+1)'(count);
    sts.sift_stop  = lk <= cand.key;
    sts.split      = {2'b0, key} > ({1'b0, need} + 18'(HEADER_BYTES));
    sts.full       = count >= CNT_W'(HEAP_ENTRIES);
    sts.i_zero     = i == '0;
    sts.up_stop    = h_rdata.key <= lk;
    sts.count      = count;

    h_we    = 1'b0;
    h_waddr = i;
    h_wdata = '{key: lk, addr: la};
    h_raddr = '0;
    t_we    = 1'b0;
    t_waddr = hdr[15:2];
    t_wdata = res_gsize;
    t_raddr = free_hdr[15:2];
    case (cmd.op)
      OP_INIT: begin
        t_we    = sts.region_big;
        t_waddr = '0;
        t_wdata = init_key;
      end
      OP_POP_BEGIN: h_raddr = HEAP_AW'(count - 1'b1);
      OP_RD_L:      h_raddr = l_idx[HEAP_AW-1:0];
      OP_LD_L:      h_raddr = r_idx[HEAP_AW-1:0];
      OP_RD_UP:     h_raddr = up_idx;
      OP_WR_LK:     h_we = 1'b1;
      OP_MOVE_DN: begin
        h_we    = 1'b1;
        h_wdata = cand;
      end
      OP_MOVE_UP: begin
        h_we    = 1'b1;
        h_wdata = h_rdata;
      end
      OP_SPLIT: begin
        t_we    = 1'b1;
        t_waddr = nhdr[15:2];
        t_wdata = nkey;
      end
      OP_FIN:  t_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region <= REG_W'(REGION_MAX);
      count  <= '0;
    end else begin
      if (cfg_we) begin
        region <= cfg_wdata;
      end
      case (cmd.op)
        OP_INIT:      count <= '0;
        OP_POP_BEGIN: count <= count - 1'b1;
        OP_PUT:       count <= count + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_st) begin
      res_st <= cmd.st;
    end
    case (cmd.op)
      OP_CAPTURE: begin
        mode      <= in_mode;
        addr_r    <= in_addr;
        need      <= ({1'b0, in_req} + 17'd3) & ~17'd3;
        res_st    <= ST_OK;
        res_gaddr <= '0;
        res_gsize <= '0;
      end
      OP_INIT: begin
        lk <= init_key;
        la <= '0;
      end
      OP_RD_TAB: la <= free_hdr;
      OP_LD_TAB: lk <= t_rdata;
      OP_POP_BEGIN: begin
        key <= h_rdata.key;
        hdr <= h_rdata.addr;
      end
      OP_POP_LAST: begin
        lk <= h_rdata.key;
        la <= h_rdata.addr;
        i  <= '0;
      end
      OP_LD_L: begin
        cand <= h_rdata;
        cidx <= l_idx[HEAP_AW-1:0];
      end
      OP_LD_R: begin
        if (h_rdata.key < cand.key) begin
          cand <= h_rdata;
          cidx <= r_idx[HEAP_AW-1:0];
        end
      end
      OP_MOVE_DN: i <= cidx;
      OP_SPLIT: begin
        res_gsize <= need[15:0];
        lk        <= nkey;
        la        <= nhdr;
      end
      OP_NOSPLIT: res_gsize <= key;
      OP_FIN:     res_gaddr <= hdr + 16'(HEADER_BYTES);
      OP_PUT:     i <= HEAP_AW'(count);
      OP_MOVE_UP: i <= up_idx;
      OP_EMIT: begin
        out_status <= res_st;
        out_gaddr  <= res_gaddr;
        out_gsize  <= res_gsize;
      end
      default: ;
    endcase
  end

endmodule

### sv/mhba_ctrl.sv
// Controller: sequences one operation at a time through the datapath.
// Depends on mhba_pkg; drives mhba_dp by command, reads its status.
`timescale 1ns / 1ps
module mhba_ctrl
  import mhba_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  state_t after_put;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '{op: OP_NONE, set_st: 1'b0, st: ST_OK};
    in_ready       = state == S_IDLE;
    out_valid_next = out_valid && !out_ready;
    after_put      = (sts.mode == MODE_ALLOC) ? S_FIN : S_DONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.mode)
          MODE_ALLOC: begin
            if (sts.empty) begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_NOFIT;
              state_next = S_DONE;
            end else begin
              cmd.op     = OP_RD_ROOT;
              state_next = S_ROOT;
            end
          end
          MODE_FREE: begin
            if (sts.addr_low) begin
              state_next = S_DONE;
            end else begin
              cmd.op     = OP_RD_TAB;
              state_next = S_FKEY;
            end
          end
          MODE_INIT: begin
            cmd.op     = OP_INIT;
            state_next = sts.region_big ? S_PUT : S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_ROOT: begin
        if (sts.nofit) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_NOFIT;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_POP_BEGIN;
          state_next = S_PLAST;
        end
      end
      S_PLAST: begin
        cmd.op     = OP_POP_LAST;
        state_next = S_PCHK;
      end
      S_PCHK: begin
        if (sts.child_ok) begin
          cmd.op     = OP_RD_L;
          state_next = S_PL;
        end else begin
          cmd.op     = OP_WR_LK;
          state_next = S_GRANT;
        end
      end
      S_PL: begin
        cmd.op     = OP_LD_L;
        state_next = S_PR;
      end
      S_PR: begin
        if (sts.right_ok) begin
          cmd.op = OP_LD_R;
        end
        state_next = S_PCMP;
      end
      S_PCMP: begin
        if (sts.sift_stop) begin
          cmd.op     = OP_WR_LK;
          state_next = S_GRANT;
        end else begin
          cmd.op     = OP_MOVE_DN;
          state_next = S_PCHK;
        end
      end
      S_GRANT: begin
        if (sts.split) begin
          cmd.op     = OP_SPLIT;
          state_next = S_PUT;
        end else begin
          cmd.op     = OP_NOSPLIT;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op     = OP_FIN;
        state_next = S_DONE;
      end
      S_FKEY: begin
        cmd.op     = OP_LD_TAB;
        state_next = S_PUT;
      end
      S_PUT: begin
        if (sts.full) begin
          cmd.set_st = sts.mode == MODE_FREE;
          cmd.st     = ST_FULL;
          state_next = after_put;
        end else begin
          cmd.op     = OP_PUT;
          state_next = S_UCHK;
        end
      end
      S_UCHK: begin
        if (sts.i_zero) begin
          cmd.op     = OP_WR_LK;
          state_next = after_put;
        end else begin
          cmd.op     = OP_RD_UP;
          state_next = S_UCMP;
        end
      end
      S_UCMP: begin
        if (sts.up_stop) begin
          cmd.op     = OP_WR_LK;
          state_next = after_put;
        end else begin
          cmd.op     = OP_MOVE_UP;
          state_next = S_UCHK;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.op         = OP_EMIT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### tb/mhba_checker.sv
// Checker for the min-heap block allocator: watches the input, output and config
// channels, predicts each result with its own heap model and compares. Uses mhba_pkg.
`timescale 1ns / 1ps
module mhba_checker
  import mhba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [31:0]      s_tdata,
  input  logic [1:0]       s_tuser,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [31:0]      m_tdata,
  input  logic [1:0]       m_tuser,
  input  logic             cfg_we,
  input  logic [REG_W-1:0] cfg_wdata,
  output int               errors
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] gaddr;
    logic [15:0] gsize;
  } grant_t;

  logic [KEY_W-1:0] free_key  [HEAP_ENTRIES];
  logic [KEY_W-1:0] free_hdr  [HEAP_ENTRIES];
  logic [KEY_W-1:0] blk_bytes [TAB_DEPTH];
  int               free_cnt;
  int               region;
  grant_t           grants_due[$];

  function automatic bit free_list_push(int key, int hdr);
    int i;
    int up;
    if (free_cnt >= HEAP_ENTRIES) return 1'b0;
    i = free_cnt;
    free_cnt++;
    while (i > 0) begin
      up = (i - 1) / 2;
      if (int'(free_key[up[HEAP_AW-1:0]]) <= key) break;
      free_key[i[HEAP_AW-1:0]] = free_key[up[HEAP_AW-1:0]];
      free_hdr[i[HEAP_AW-1:0]] = free_hdr[up[HEAP_AW-1:0]];
      i = up;
    end
    free_key[i[HEAP_AW-1:0]] = KEY_W'(key);
    free_hdr[i[HEAP_AW-1:0]] = KEY_W'(hdr);
    return 1'b1;
  endfunction

  function automatic void free_list_pop_min();
    int lk;
    int la;
    int i;
    int l;
    int r;
    int s;
    i = 0;
    free_cnt--;
    lk = int'(free_key[free_cnt[HEAP_AW-1:0]]);
    la = int'(free_hdr[free_cnt[HEAP_AW-1:0]]);
    while (2 * i + 1 < free_cnt) begin
      l = 2 * i + 1;
      r = l + 1;
      s = (r < free_cnt && free_key[r[HEAP_AW-1:0]] < free_key[l[HEAP_AW-1:0]]) ? r : l;
      if (lk <= int'(free_key[s[HEAP_AW-1:0]])) break;
      free_key[i[HEAP_AW-1:0]] = free_key[s[HEAP_AW-1:0]];
      free_hdr[i[HEAP_AW-1:0]] = free_hdr[s[HEAP_AW-1:0]];
      i = s;
    end
    free_key[i[HEAP_AW-1:0]] = KEY_W'(lk);
    free_hdr[i[HEAP_AW-1:0]] = KEY_W'(la);
  endfunction

  function automatic grant_t predict_grant(logic [1:0] mode, int req, int addr);
    grant_t g;
    int need;
    int key;
    int hdr;
    int nhdr;
    int lim;
    g = '0;
    g.status = ST_OK;
    if (mode == MODE_ALLOC) begin
      need = (req + 3) & ~3;
      if (free_cnt == 0 || int'(free_key[0]) < need) begin
        g.status = ST_NOFIT;
      end else begin
        key = int'(free_key[0]);
        hdr = int'(free_hdr[0]);
        free_list_pop_min();
        // split off the tail when it can carry a header of its own
        if (key > need + HEADER_BYTES) begin
          nhdr = (hdr + HEADER_BYTES + need) % REGION_MAX;
          blk_bytes[nhdr[KEY_W-1:2]] = KEY_W'(key - need - HEADER_BYTES);
          void'(free_list_push(key - need - HEADER_BYTES, nhdr));
          key = need;
        end
        blk_bytes[hdr[KEY_W-1:2]] = KEY_W'(key);
        g.gaddr = 16'((hdr + HEADER_BYTES) % REGION_MAX);
        g.gsize = 16'(key);
      end
    end else if (mode == MODE_FREE) begin
      if (addr >= HEADER_BYTES) begin
        hdr = (addr - HEADER_BYTES) % REGION_MAX;
        if (!free_list_push(int'(blk_bytes[hdr[KEY_W-1:2]]), hdr)) g.status = ST_FULL;
      end
    end else if (mode == MODE_INIT) begin
      lim = (region > REGION_MAX) ? REGION_MAX : region;
      free_cnt = 0;
      if (lim > HEADER_BYTES) begin
        blk_bytes[0] = KEY_W'(lim - HEADER_BYTES);
        void'(free_list_push(lim - HEADER_BYTES, 0));
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      free_cnt = 0;
      region = REGION_MAX;
      grants_due.delete();
      errors = 0;
    end else begin
      if (cfg_we) region = int'(cfg_wdata);
      if (m_tvalid && m_tready) begin
        if (grants_due.size() == 0) begin
          $display("%0t mhba_checker: unexpected result, expected none, got %h",
                   $time, {m_tuser, m_tdata});
          errors++;
        end else begin
          want = grants_due.pop_front();
          if (m_tuser !== want.status) begin
            $display("%0t mhba_checker: status expected %0d, got %0d",
                     $time, want.status, m_tuser);
            errors++;
          end
          if (m_tdata[15:0] !== want.gaddr) begin
            $display("%0t mhba_checker: granted_addr expected %h, got %h",
                     $time, want.gaddr, m_tdata[15:0]);
            errors++;
          end
          if (m_tdata[31:16] !== want.gsize) begin
            $display("%0t mhba_checker: granted_size expected %h, got %h",
                     $time, want.gsize, m_tdata[31:16]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready)
        grants_due.push_back(predict_grant(s_tuser, int'(s_tdata[15:0]),
                                           int'(s_tdata[31:16])));
    end
  end

endmodule

### tb/tb_top.sv
// Top of the allocator testbench: clock, reset, stimulus, output backpressure, verdict.
// Depends on mhba_pkg, min_heap_block_allocator_top and mhba_checker.
`timescale 1ns / 1ps
module tb_top
  import mhba_pkg::*;
();

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [31:0]      s_tdata = '0;   // [15:0] req_size, [31:16] addr
  logic [1:0]       s_tuser = '0;   // [1:0] mode
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [31:0]      m_tdata;        // [15:0] granted_addr, [31:16] granted_size
  logic [1:0]       m_tuser;        // [1:0] status
  logic             cfg_we = 1'b0;
  logic [REG_W-1:0] cfg_wdata = '0;

  int          errors;
  int          beats_in;
  int          beats_out;
  int          full_seen;
  int          nofit_seen;
  bit          quiet;          // no idling on either side
  bit          hold_pending;   // receiver takes a long hold-off when set
  logic [15:0] granted[$];     // user areas handed out so far; safe to free

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  min_heap_block_allocator_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  mhba_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .errors(errors)
  );

  // Count result beats and remember every granted user area so that frees only
  // ever name blocks whose size has been recorded.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      beats_out++;
      if (m_tuser == ST_OK && m_tdata[15:0] != 16'd0) granted.push_back(m_tdata[15:0]);
      if (m_tuser == ST_FULL) full_seen++;
      if (m_tuser == ST_NOFIT) nofit_seen++;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request that
  // lets the block fill its output register and stall its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one beat and hold it until the block takes it; sometimes idle first.
  task automatic send_beat(logic [1:0] mode, logic [15:0] req, logic [15:0] addr);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {addr, req};
    do @(posedge clk); while (!s_tready);
    beats_in++;
  endtask

  // Let every result drain, then give any trailing work time to settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (beats_out != beats_in);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_region(logic [REG_W-1:0] bytes);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= bytes;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [15:0] pick_granted();
    return granted[$urandom_range(0, granted.size() - 1)];
  endfunction

  // One random operation: mostly allocate and free of live blocks, with some
  // ignored frees, rare inits and the unused mode.
  task automatic random_beat();
    int r;
    logic [15:0] req;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      case ($urandom_range(0, 19))
        0:       req = 16'($urandom_range(0, 65535));
        1, 2, 3: req = 16'($urandom_range(0, 3000));
        default: req = 16'($urandom_range(0, 64));
      endcase
      send_beat(MODE_ALLOC, req, 16'($urandom_range(0, 65535)));
    end else if (r < 95) begin
      if (granted.size() != 0 && $urandom_range(0, 9) != 0)
        send_beat(MODE_FREE, 16'($urandom_range(0, 65535)), pick_granted());
      else
        send_beat(MODE_FREE, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, HEADER_BYTES - 1)));
    end else if (r < 97) begin
      send_beat(MODE_INIT, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    end else begin
      send_beat(MODE_NOP, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full region, smallest and largest requests, ignored frees,
    // a real free and the unused mode.
    send_beat(MODE_INIT, 16'd0, 16'd0);
    send_beat(MODE_ALLOC, 16'd0, 16'd0);
    send_beat(MODE_ALLOC, 16'd1, 16'hFFFF);
    send_beat(MODE_ALLOC, 16'hFFFF, 16'd0);
    send_beat(MODE_ALLOC, 16'd5, 16'd0);
    send_beat(MODE_FREE, 16'd0, 16'd0);
    send_beat(MODE_FREE, 16'hFFFF, 16'(HEADER_BYTES - 1));
    drain();
    send_beat(MODE_FREE, 16'd0, pick_granted());
    send_beat(MODE_NOP, 16'hFFFF, 16'hFFFF);
    send_beat(MODE_ALLOC, 16'd3, 16'd0);

    // Small region: a request too big for the lone block, then one that takes the whole
    // block without a split, then an empty heap.
    set_region(17'd100);
    send_beat(MODE_INIT, 16'd0, 16'd0);
    send_beat(MODE_ALLOC, 16'd80, 16'd0);
    send_beat(MODE_ALLOC, 16'd50, 16'd0);
    send_beat(MODE_ALLOC, 16'd4, 16'd0);

    // Regions at or below one header leave the heap empty.
    set_region(REG_W'(HEADER_BYTES));
    send_beat(MODE_INIT, 16'd0, 16'd0);
    send_beat(MODE_ALLOC, 16'd0, 16'd0);
    set_region(17'd0);
    send_beat(MODE_INIT, 16'd0, 16'd0);
    send_beat(MODE_ALLOC, 16'd0, 16'd0);

    // Register above the maximum saturates; random mix on the full region.
    set_region(17'h1FFFF);
    send_beat(MODE_INIT, 16'd0, 16'd0);
    repeat (100) random_beat();

    // Fill the heap: free live blocks over and over until frees get dropped.
    repeat (8) send_beat(MODE_ALLOC, 16'($urandom_range(0, 40)), 16'd0);
    drain();
    repeat (1040) send_beat(MODE_FREE, 16'($urandom_range(0, 65535)), pick_granted());

    // Long hold-off on the result side while beats keep coming.
    set_region(REG_W'(REGION_MAX));
    send_beat(MODE_INIT, 16'd0, 16'd0);
    hold_pending = 1'b1;
    repeat (100) random_beat();

    set_region(REG_W'($urandom_range(200, 5000)));
    send_beat(MODE_INIT, 16'd0, 16'd0);
    repeat (60) random_beat();

    // Final stretch at full rate.
    set_region(REG_W'(REGION_MAX));
    quiet = 1'b1;
    send_beat(MODE_INIT, 16'd0, 16'd0);
    repeat (60) random_beat();
    drain();

    $display("tb_top: %0d beats in, %0d results, %0d heap-full drops, %0d failed allocs",
             beats_in, beats_out, full_seen, nofit_seen);
    $display("tb_top: region settings 0, header, 100, saturated, full and one random");
    if (errors == 0 && beats_in == beats_out) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_top: timeout");
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
